FILE: rtl/mpbl_pkg.sv
// ----------------------------------------------------------------------------
// mpbl_pkg
// Shared types and constants for the motor power burnout limiter.
// ----------------------------------------------------------------------------
package mpbl_pkg;

	localparam int NUM_MOTORS_DEF = 4;
	localparam int MOTOR_W        = 2;
	localparam int POWER_W        = 16;
	localparam int SPEED_W        = 31;
	localparam int BASE_W         = 15;
	localparam int GAIN_W         = 31;
	localparam int LIMIT_W        = 15;
	localparam int PWM_W          = 11;
	localparam int CFG_IDX_W      = 4;
	localparam int CFG_DATA_W     = 31;
	localparam int NUM_REG_MOTORS = 4;

	localparam int GAIN_FRAC      = 16;
	localparam int PROD_W         = SPEED_W + GAIN_W;
	localparam int EXTRA_W        = PROD_W - GAIN_FRAC;

	localparam logic [LIMIT_W-1:0] LIMIT_MAX = 15'h7FFF;

	// divide by 41 as multiply by reciprocal, exact for magnitudes below 2^15
	localparam int PWM_STEP       = 41;
	localparam int RECIP_SHIFT    = 21;
	localparam int RECIP_W        = 16;
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'(((1 << RECIP_SHIFT) + PWM_STEP - 1) / PWM_STEP);
	localparam int QUOT_W         = 10;
	localparam logic [QUOT_W-1:0] PWM_CLAMP = 10'd798;

	localparam logic [BASE_W-1:0] BASE_RST_LEFT  = 15'd4096;
	localparam logic [BASE_W-1:0] BASE_RST_RIGHT = 15'd4096;
	localparam logic [BASE_W-1:0] BASE_RST_LIFT  = 15'd2048;
	localparam logic [BASE_W-1:0] BASE_RST_HEAD  = 15'd4096;
	localparam logic [GAIN_W-1:0] GAIN_RST_LEFT  = 31'd1073741824;
	localparam logic [GAIN_W-1:0] GAIN_RST_RIGHT = 31'd1073741824;
	localparam logic [GAIN_W-1:0] GAIN_RST_LIFT  = 31'd1073741824;
	localparam logic [GAIN_W-1:0] GAIN_RST_HEAD  = 31'd536870912;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BASE_LEFT  = 4'd0,
		REG_BASE_RIGHT = 4'd1,
		REG_BASE_LIFT  = 4'd2,
		REG_BASE_HEAD  = 4'd3,
		REG_GAIN_LEFT  = 4'd4,
		REG_GAIN_RIGHT = 4'd5,
		REG_GAIN_LIFT  = 4'd6,
		REG_GAIN_HEAD  = 4'd7
	} reg_idx_t;

	typedef logic [BASE_W-1:0] base_arr_t [NUM_REG_MOTORS];
	typedef logic [GAIN_W-1:0] gain_arr_t [NUM_REG_MOTORS];

	typedef struct packed {
		logic [MOTOR_W-1:0]        sel;
		logic signed [POWER_W-1:0] power;
		logic                      charger;
		logic [SPEED_W-1:0]        speed;
	} req_t;

	typedef struct packed {
		logic [MOTOR_W-1:0]        sel;
		logic signed [POWER_W-1:0] power;
		logic [LIMIT_W-1:0]        inst;
	} lim_t;

	typedef struct packed {
		logic               ok;
		logic               neg;
		logic [LIMIT_W-1:0] mag;
		logic [LIMIT_W-1:0] cap;
	} lvl_t;

endpackage

FILE: rtl/mpbl_if.sv
// ----------------------------------------------------------------------------
// mpbl_if
// Request, result and register write channels of the burnout limiter.
// ----------------------------------------------------------------------------
interface mpbl_req_if;
	logic                                valid;
	logic                                ready;
	logic [mpbl_pkg::MOTOR_W-1:0]        motor_sel;
	logic signed [mpbl_pkg::POWER_W-1:0] power_request;
	logic                                on_charger;
	logic [mpbl_pkg::SPEED_W-1:0]        speed_mag;

	modport source (output valid, motor_sel, power_request, on_charger, speed_mag,
		input ready);
	modport sink (input valid, motor_sel, power_request, on_charger, speed_mag,
		output ready);
endinterface

interface mpbl_res_if;
	logic                              valid;
	logic                              ready;
	logic signed [mpbl_pkg::PWM_W-1:0] pwm_level;
	logic [mpbl_pkg::LIMIT_W-1:0]      power_cap;

	modport source (output valid, pwm_level, power_cap, input ready);
	modport sink (input valid, pwm_level, power_cap, output ready);
endinterface

interface mpbl_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [mpbl_pkg::CFG_IDX_W-1:0]  index;
	logic [mpbl_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/motor_power_burnout_limiter.sv
// ----------------------------------------------------------------------------
// motor_power_burnout_limiter
// Limits per-motor drive power with a running-average burnout cap.
// ----------------------------------------------------------------------------
// req carries one request beat per motor update: motor number, signed power,
// charger flag and speed magnitude. res returns one beat per request with the
// signed pwm level and the averaged cap now in force for that motor. cfg
// writes the base limits (index 0..3) and speed gains (index 4..7); other
// indexes are dropped. cfg is always ready; write only while no request is in
// flight.
// The path is four register stages: input, speed product and saturation,
// average update with request clamp, divide and clamp into the result
// register. One beat is taken every cycle while res accepts results; the
// average state is read and written in one stage, so back-to-back beats to
// the same motor see each other's update.
// When res stalls, each stage still fills its empty slot, so up to four
// beats are held before req.ready drops.
// Reset clears stage valids and averages to zero and loads register defaults.
// ----------------------------------------------------------------------------
module motor_power_burnout_limiter #(
	parameter int NUM_MOTORS = mpbl_pkg::NUM_MOTORS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	mpbl_req_if.sink  req,
	mpbl_res_if.source res,
	mpbl_cfg_if.sink  cfg
);

	mpbl_pkg::base_arr_t base;
	mpbl_pkg::gain_arr_t gain;
	mpbl_pkg::req_t      req_s1;
	mpbl_pkg::lim_t      lim_s2;
	mpbl_pkg::lvl_t      lvl_s3;

	logic v_s1, v_s2, v_s3, v_s4;
	logic free1, free2, free3, free4;
	logic ld1, ld2, ld3, ld4;

	always_comb begin
		free4 = !v_s4 || res.ready;
		ld4   = v_s3 && free4;
		free3 = !v_s3 || ld4;
		ld3   = v_s2 && free3;
		free2 = !v_s2 || ld3;
		ld2   = v_s1 && free2;
		free1 = !v_s1 || ld2;
		ld1   = req.valid && free1;
	end

	assign req.ready = free1;
	assign res.valid = v_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (free1) v_s1 <= req.valid;
			if (free2) v_s2 <= v_s1;
			if (free3) v_s3 <= v_s2;
			if (free4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (ld1) begin
			req_s1.sel     <= req.motor_sel;
			req_s1.power   <= req.power_request;
			req_s1.charger <= req.on_charger;
			req_s1.speed   <= req.speed_mag;
		end
	end

	mpbl_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.base   (base),
		.gain   (gain)
	);

	mpbl_limit u_limit (
		.clk    (clk),
		.ld     (ld2),
		.req_s1 (req_s1),
		.base   (base),
		.gain   (gain),
		.lim_s2 (lim_s2)
	);

	mpbl_avg #(
		.NUM_MOTORS (NUM_MOTORS)
	) u_avg (
		.clk    (clk),
		.arst_n (arst_n),
		.ld     (ld3),
		.lim_s2 (lim_s2),
		.lvl_s3 (lvl_s3)
	);

	mpbl_pwm u_pwm (
		.clk          (clk),
		.ld           (ld4),
		.lvl_s3       (lvl_s3),
		.pwm_level_s4 (res.pwm_level),
		.power_cap_s4 (res.power_cap)
	);

endmodule

FILE: rtl/mpbl_cfg_regs.sv
// ----------------------------------------------------------------------------
// mpbl_cfg_regs
// Per-motor base limit and speed gain registers.
// ----------------------------------------------------------------------------
module mpbl_cfg_regs (
	input  logic                 clk,
	input  logic                 arst_n,
	mpbl_cfg_if.sink             cfg,
	output mpbl_pkg::base_arr_t  base,
	output mpbl_pkg::gain_arr_t  gain
);

	mpbl_pkg::base_arr_t base_q;
	mpbl_pkg::gain_arr_t gain_q;
	logic                wr;
	logic [mpbl_pkg::BASE_W-1:0] wdata_base;

	assign cfg.ready  = 1'b1;
	assign wr         = cfg.valid & cfg.ready;
	assign wdata_base = cfg.data[mpbl_pkg::BASE_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q[0] <= mpbl_pkg::BASE_RST_LEFT;
			base_q[1] <= mpbl_pkg::BASE_RST_RIGHT;
			base_q[2] <= mpbl_pkg::BASE_RST_LIFT;
			base_q[3] <= mpbl_pkg::BASE_RST_HEAD;
			gain_q[0] <= mpbl_pkg::GAIN_RST_LEFT;
			gain_q[1] <= mpbl_pkg::GAIN_RST_RIGHT;
			gain_q[2] <= mpbl_pkg::GAIN_RST_LIFT;
			gain_q[3] <= mpbl_pkg::GAIN_RST_HEAD;
		end else if (wr) begin
			case (cfg.index)
				mpbl_pkg::REG_BASE_LEFT:  base_q[0] <= wdata_base;
				mpbl_pkg::REG_BASE_RIGHT: base_q[1] <= wdata_base;
				mpbl_pkg::REG_BASE_LIFT:  base_q[2] <= wdata_base;
				mpbl_pkg::REG_BASE_HEAD:  base_q[3] <= wdata_base;
				mpbl_pkg::REG_GAIN_LEFT:  gain_q[0] <= cfg.data;
				mpbl_pkg::REG_GAIN_RIGHT: gain_q[1] <= cfg.data;
				mpbl_pkg::REG_GAIN_LIFT:  gain_q[2] <= cfg.data;
				mpbl_pkg::REG_GAIN_HEAD:  gain_q[3] <= cfg.data;
				default: ;
			endcase
		end
	end

	assign base = base_q;
	assign gain = gain_q;

endmodule

FILE: rtl/mpbl_limit.sv
// ----------------------------------------------------------------------------
// mpbl_limit
// Instantaneous limit: base plus scaled speed on the charger, saturated.
// ----------------------------------------------------------------------------
module mpbl_limit (
	input  logic                clk,
	input  logic                ld,
	input  mpbl_pkg::req_t      req_s1,
	input  mpbl_pkg::base_arr_t base,
	input  mpbl_pkg::gain_arr_t gain,
	output mpbl_pkg::lim_t      lim_s2
);

	logic [mpbl_pkg::PROD_W-1:0]  prod;
	logic [mpbl_pkg::EXTRA_W-1:0] extra;
	logic [mpbl_pkg::BASE_W:0]    sum;
	logic                         sat;
	logic [mpbl_pkg::LIMIT_W-1:0] inst;
	mpbl_pkg::lim_t               lim_s2_r;

	always_comb begin
		prod  = mpbl_pkg::PROD_W'(req_s1.speed) * mpbl_pkg::PROD_W'(gain[req_s1.sel]);
		extra = prod[mpbl_pkg::PROD_W-1:mpbl_pkg::GAIN_FRAC];
		sum   = {1'b0, base[req_s1.sel]} + {1'b0, extra[mpbl_pkg::LIMIT_W-1:0]};
		sat   = (|extra[mpbl_pkg::EXTRA_W-1:mpbl_pkg::LIMIT_W]) | sum[mpbl_pkg::BASE_W];
		if (!req_s1.charger || sat) begin
			inst = mpbl_pkg::LIMIT_MAX;
		end else begin
			inst = sum[mpbl_pkg::LIMIT_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			lim_s2_r.sel   <= req_s1.sel;
			lim_s2_r.power <= req_s1.power;
			lim_s2_r.inst  <= inst;
		end
	end

	assign lim_s2 = lim_s2_r;

endmodule

FILE: rtl/mpbl_avg.sv
// ----------------------------------------------------------------------------
// mpbl_avg
// Per-motor averaged limit and clamp of the request to that limit.
// ----------------------------------------------------------------------------
module mpbl_avg #(
	parameter int NUM_MOTORS = mpbl_pkg::NUM_MOTORS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           ld,
	input  mpbl_pkg::lim_t lim_s2,
	output mpbl_pkg::lvl_t lvl_s3
);

	localparam int IDX_W = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;
	localparam int SUM_W = mpbl_pkg::LIMIT_W + 4;

	logic [mpbl_pkg::LIMIT_W-1:0] avg_q [NUM_MOTORS];
	logic [IDX_W-1:0]             idx;
	logic                         ok;
	logic [mpbl_pkg::LIMIT_W-1:0] avg;
	logic [SUM_W-1:0]             sum;
	logic [mpbl_pkg::LIMIT_W-1:0] cap;
	logic                         neg;
	logic [mpbl_pkg::POWER_W:0]   pmag;
	logic [mpbl_pkg::LIMIT_W-1:0] mag;
	mpbl_pkg::lvl_t               lvl_s3_r;

	always_comb begin
		idx  = IDX_W'(lim_s2.sel);
		ok   = int'(lim_s2.sel) < NUM_MOTORS;
		avg  = ok ? avg_q[idx] : '0;
		// (inst + 15*avg) / 16
		sum  = SUM_W'(lim_s2.inst) + {avg, 4'b0000} - SUM_W'(avg);
		cap  = sum[SUM_W-1:4];
		neg  = lim_s2.power[mpbl_pkg::POWER_W-1];
		pmag = neg ? (~{1'b1, lim_s2.power} + 17'd1) : {1'b0, lim_s2.power};
		mag  = (pmag > {2'b00, cap}) ? cap : pmag[mpbl_pkg::LIMIT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_MOTORS; i++) begin
				avg_q[i] <= '0;
			end
		end else if (ld && ok) begin
			avg_q[idx] <= cap;
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			lvl_s3_r.ok  <= ok;
			lvl_s3_r.neg <= neg;
			lvl_s3_r.mag <= mag;
			lvl_s3_r.cap <= cap;
		end
	end

	assign lvl_s3 = lvl_s3_r;

endmodule

FILE: rtl/mpbl_pwm.sv
// ----------------------------------------------------------------------------
// mpbl_pwm
// Scale the clamped level to the pwm range and hold the result beat.
// ----------------------------------------------------------------------------
module mpbl_pwm (
	input  logic                              clk,
	input  logic                              ld,
	input  mpbl_pkg::lvl_t                    lvl_s3,
	output logic signed [mpbl_pkg::PWM_W-1:0] pwm_level_s4,
	output logic [mpbl_pkg::LIMIT_W-1:0]      power_cap_s4
);

	localparam int MP_W = mpbl_pkg::LIMIT_W + mpbl_pkg::RECIP_W;

	logic [MP_W-1:0]                 mp;
	logic [mpbl_pkg::QUOT_W-1:0]     quot;
	logic [mpbl_pkg::QUOT_W-1:0]     qc;
	logic [mpbl_pkg::PWM_W-1:0]      qx;
	logic signed [mpbl_pkg::PWM_W-1:0] level;

	always_comb begin
		mp    = MP_W'(lvl_s3.mag) * MP_W'(mpbl_pkg::RECIP);
		quot  = mp[mpbl_pkg::RECIP_SHIFT +: mpbl_pkg::QUOT_W];
		qc    = (quot > mpbl_pkg::PWM_CLAMP) ? mpbl_pkg::PWM_CLAMP : quot;
		qx    = {1'b0, qc};
		level = lvl_s3.neg ? $signed(~qx + 11'd1) : $signed(qx);
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			pwm_level_s4 <= lvl_s3.ok ? level : '0;
			power_cap_s4 <= lvl_s3.ok ? lvl_s3.cap : '0;
		end
	end

endmodule

FILE: sim/motor_power_burnout_limiter_checker.sv
// ----------------------------------------------------------------------------
// motor_power_burnout_limiter_checker
// Watches the request, result and register channels of the limiter, keeps
// its own copy of the limits, gains and per-motor averages, predicts pwm
// level and power cap for every request beat, and compares every result
// beat with the oldest prediction. Mismatches are counted and handed out.
// ----------------------------------------------------------------------------
module motor_power_burnout_limiter_checker #(
	parameter int NUM_MOTORS = mpbl_pkg::NUM_MOTORS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	mpbl_req_if  req,
	mpbl_res_if  res,
	mpbl_cfg_if  cfg,
	input  logic end_check,
	output int   pending,
	output int   fail_count
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SUM_W      = mpbl_pkg::EXTRA_W + 1;
	localparam int BLEND_W    = mpbl_pkg::LIMIT_W + 5;
	localparam int AVG_WEIGHT = 15;
	localparam int AVG_SHIFT  = 4;

	localparam logic [mpbl_pkg::BASE_W-1:0] BASE_DEF [mpbl_pkg::NUM_REG_MOTORS] =
		'{mpbl_pkg::BASE_RST_LEFT, mpbl_pkg::BASE_RST_RIGHT, mpbl_pkg::BASE_RST_LIFT,
		mpbl_pkg::BASE_RST_HEAD};
	localparam logic [mpbl_pkg::GAIN_W-1:0] GAIN_DEF [mpbl_pkg::NUM_REG_MOTORS] =
		'{mpbl_pkg::GAIN_RST_LEFT, mpbl_pkg::GAIN_RST_RIGHT, mpbl_pkg::GAIN_RST_LIFT,
		mpbl_pkg::GAIN_RST_HEAD};

	typedef struct {
		logic signed [mpbl_pkg::PWM_W-1:0] pwm;
		logic [mpbl_pkg::LIMIT_W-1:0]      cap;
	} drive_out_t;

	logic [mpbl_pkg::BASE_W-1:0]  base_lim [mpbl_pkg::NUM_REG_MOTORS];
	logic [mpbl_pkg::GAIN_W-1:0]  speed_gain [mpbl_pkg::NUM_REG_MOTORS];
	logic [mpbl_pkg::LIMIT_W:0]   avg_lim [NUM_MOTORS];
	drive_out_t                   drive_q [$];
	drive_out_t                   oldest;
	int                           mismatches = 0;
	logic                         end_seen;

	assign fail_count = mismatches;

	task automatic report(input string msg);
		$display("mismatch at %0t: %s", $time, msg);
		mismatches++;
	endtask

	function automatic drive_out_t limit_request(input logic [mpbl_pkg::MOTOR_W-1:0] sel,
		input logic signed [mpbl_pkg::POWER_W-1:0] power, input logic charger,
		input logic [mpbl_pkg::SPEED_W-1:0] speed);
		logic [mpbl_pkg::PROD_W-1:0]  prod;
		logic [SUM_W-1:0]             lim_sum;
		logic [mpbl_pkg::LIMIT_W-1:0] lim_now;
		logic [BLEND_W-1:0]           blend;
		int                           lvl;
		int                           cap_i;
		drive_out_t                   r;
		r.pwm = '0;
		r.cap = '0;
		if (int'(sel) >= NUM_MOTORS)
			return r;
		if (charger) begin
			prod    = mpbl_pkg::PROD_W'(speed) * mpbl_pkg::PROD_W'(speed_gain[sel]);
			lim_sum = SUM_W'(base_lim[sel]) + SUM_W'(prod >> mpbl_pkg::GAIN_FRAC);
			lim_now = (lim_sum > SUM_W'(mpbl_pkg::LIMIT_MAX)) ? mpbl_pkg::LIMIT_MAX
				: lim_sum[mpbl_pkg::LIMIT_W-1:0];
		end else begin
			lim_now = mpbl_pkg::LIMIT_MAX;
		end
		blend = BLEND_W'(lim_now) + BLEND_W'(avg_lim[sel]) * BLEND_W'(AVG_WEIGHT);
		avg_lim[sel] = (mpbl_pkg::LIMIT_W+1)'(blend >> AVG_SHIFT);
		r.cap = avg_lim[sel][mpbl_pkg::LIMIT_W-1:0];
		cap_i = int'(r.cap);
		lvl   = int'(power);
		if (lvl > cap_i)
			lvl = cap_i;
		else if (lvl < -cap_i)
			lvl = -cap_i;
		lvl = lvl / mpbl_pkg::PWM_STEP;
		if (lvl > int'(mpbl_pkg::PWM_CLAMP))
			lvl = int'(mpbl_pkg::PWM_CLAMP);
		else if (lvl < -int'(mpbl_pkg::PWM_CLAMP))
			lvl = -int'(mpbl_pkg::PWM_CLAMP);
		r.pwm = mpbl_pkg::PWM_W'(lvl);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < mpbl_pkg::NUM_REG_MOTORS; i++) begin
				base_lim[i]   = BASE_DEF[i];
				speed_gain[i] = GAIN_DEF[i];
			end
			for (int i = 0; i < NUM_MOTORS; i++)
				avg_lim[i] = '0;
			drive_q.delete();
			end_seen = 1'b0;
			pending  = 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				if (cfg.index <= mpbl_pkg::REG_BASE_HEAD)
					base_lim[cfg.index[1:0]] = cfg.data[mpbl_pkg::BASE_W-1:0];
				else if (cfg.index <= mpbl_pkg::REG_GAIN_HEAD)
					speed_gain[cfg.index[1:0]] = cfg.data[mpbl_pkg::GAIN_W-1:0];
			end
			if (req.valid && req.ready)
				drive_q.push_back(limit_request(req.motor_sel, req.power_request,
					req.on_charger, req.speed_mag));
			if (res.valid && res.ready) begin
				if (drive_q.size() == 0) begin
					report($sformatf("result beat pwm %0d cap %0d with nothing pending",
						res.pwm_level, res.power_cap));
				end else begin
					oldest = drive_q.pop_front();
					if (res.pwm_level !== oldest.pwm)
						report($sformatf("pwm_level %0d, predicted %0d",
							res.pwm_level, oldest.pwm));
					if (res.power_cap !== oldest.cap)
						report($sformatf("power_cap %0d, predicted %0d",
							res.power_cap, oldest.cap));
				end
			end
			if (end_check && !end_seen) begin
				end_seen = 1'b1;
				if (drive_q.size() != 0)
					report($sformatf("%0d results never arrived", drive_q.size()));
			end
			pending = drive_q.size();
		end
	end

endmodule

FILE: sim/tb_motor_power_burnout_limiter.sv
// ----------------------------------------------------------------------------
// tb_motor_power_burnout_limiter
// Drives requests and register writes into the burnout limiter with random
// gaps on request and result, in phases with different limit and gain settings,
// including a long result stall that backs the pipe up. The checker beside
// the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_motor_power_burnout_limiter;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PHASES       = 6;
	localparam int PHASE_ITEMS  = 238;
	localparam int IDLE_LIMIT   = 4000;
	localparam int HOLD_CYCLES  = 80;
	localparam int DRAIN_CYCLES = 16;

	localparam logic [mpbl_pkg::BASE_W-1:0] BASE_DEF [mpbl_pkg::NUM_REG_MOTORS] =
		'{mpbl_pkg::BASE_RST_LEFT, mpbl_pkg::BASE_RST_RIGHT, mpbl_pkg::BASE_RST_LIFT,
		mpbl_pkg::BASE_RST_HEAD};
	localparam logic [mpbl_pkg::GAIN_W-1:0] GAIN_DEF [mpbl_pkg::NUM_REG_MOTORS] =
		'{mpbl_pkg::GAIN_RST_LEFT, mpbl_pkg::GAIN_RST_RIGHT, mpbl_pkg::GAIN_RST_LIFT,
		mpbl_pkg::GAIN_RST_HEAD};

	logic clk = 1'b0;
	logic arst_n;
	logic end_check;
	int   pending;
	int   fail_count;
	int   src_gap_max;
	int   snk_gap_max;
	logic hold_res;
	int   idle_cycles = 0;

	mpbl_req_if req_ch ();
	mpbl_res_if res_ch ();
	mpbl_cfg_if cfg_ch ();

	motor_power_burnout_limiter uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	motor_power_burnout_limiter_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req_ch),
		.res        (res_ch),
		.cfg        (cfg_ch),
		.end_check  (end_check),
		.pending    (pending),
		.fail_count (fail_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) ||
			(cfg_ch.valid && cfg_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic send_req(input logic [mpbl_pkg::MOTOR_W-1:0] sel,
		input logic signed [mpbl_pkg::POWER_W-1:0] pw, input logic chg,
		input logic [mpbl_pkg::SPEED_W-1:0] spd);
		int gap;
		gap = $urandom_range(0, src_gap_max);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.motor_sel     <= sel;
		req_ch.power_request <= pw;
		req_ch.on_charger    <= chg;
		req_ch.speed_mag     <= spd;
		req_ch.valid         <= 1'b1;
		do @(posedge clk); while (!(req_ch.valid && req_ch.ready));
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [mpbl_pkg::CFG_IDX_W-1:0] idx,
		input logic [mpbl_pkg::CFG_DATA_W-1:0] val);
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		cfg_ch.valid <= 1'b1;
		do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
		@(negedge clk);
	endtask

	// result side: random gap per beat, one long hold when asked
	initial begin
		int gap;
		res_ch.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (hold_res) begin
				gap = HOLD_CYCLES;
				hold_res = 1'b0;
			end else begin
				gap = $urandom_range(0, snk_gap_max);
			end
			if (gap > 0) begin
				res_ch.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			res_ch.ready <= 1'b1;
			do @(posedge clk); while (!(res_ch.valid && res_ch.ready));
			@(negedge clk);
		end
	end

	initial begin
		int                                  sent;
		int                                  burst_len;
		logic [mpbl_pkg::MOTOR_W-1:0]        burst_motor;
		logic                                burst_chg;
		logic [mpbl_pkg::MOTOR_W-1:0]        sel;
		logic signed [mpbl_pkg::POWER_W-1:0] pw;
		logic                                chg;
		logic [mpbl_pkg::SPEED_W-1:0]        spd;
		logic [mpbl_pkg::CFG_DATA_W-1:0]     base_val;
		logic [mpbl_pkg::CFG_DATA_W-1:0]     gain_val;

		req_ch.valid         = 1'b0;
		req_ch.motor_sel     = '0;
		req_ch.power_request = '0;
		req_ch.on_charger    = 1'b0;
		req_ch.speed_mag     = '0;
		cfg_ch.valid         = 1'b0;
		cfg_ch.index         = '0;
		cfg_ch.data          = '0;
		end_check            = 1'b0;
		hold_res             = 1'b0;
		src_gap_max          = 5;
		snk_gap_max          = 5;
		@(posedge arst_n);
		@(negedge clk);

		// reset limits: extremes of power, speed and motor number
		send_req(2'd0, 16'sh7FFF, 1'b0, '0);
		send_req(2'd1, 16'sh8000, 1'b1, '0);
		send_req(2'd2, 16'sh7FFF, 1'b1, 31'h7FFF_FFFF);
		send_req(2'd3, 16'sh0000, 1'b1, 31'd1);
		send_req(2'd0, -16'sd1, 1'b0, '0);
		send_req(2'd0, 16'sd1, 1'b0, '0);
		send_req(2'd0, 16'sd40, 1'b0, '0);
		send_req(2'd0, -16'sd41, 1'b0, '0);
		send_req(2'd0, -16'sd40, 1'b0, '0);
		send_req(2'd1, 16'sd82, 1'b1, 31'd2);
		send_req(2'd1, 16'sh8000, 1'b0, 31'h4000_0000);
		send_req(2'd2, -16'sd123, 1'b0, 31'h5555_5555);
		send_req(2'd3, 16'sh7FFF, 1'b1, 31'h2AAA_AAAA);
		send_req(2'd3, 16'sh8000, 1'b1, 31'h7FFF_FFFF);
		send_req(2'd2, 16'sh7FFF, 1'b0, '0);
		send_req(2'd1, 16'sh4000, 1'b1, '0);
		for (int i = 0; i < 6; i++)
			send_req(2'd3, (i % 2) ? 16'sh8000 : 16'sh7FFF, 1'b0, 31'h7FFF_FFFF);

		for (int phase = 0; phase < PHASES; phase++) begin
			req_ch.valid <= 1'b0;
			wait (pending == 0);
			repeat (4) @(negedge clk);
			for (int m = 0; m < mpbl_pkg::NUM_REG_MOTORS; m++) begin
				case (phase)
					0: begin
						base_val = '0;
						gain_val = '0;
					end
					1: begin
						base_val = '1;
						gain_val = '1;
					end
					3: begin
						base_val = mpbl_pkg::CFG_DATA_W'($urandom_range(0, 4096));
						gain_val = mpbl_pkg::CFG_DATA_W'($urandom_range(0, 1 << 18));
					end
					4: begin
						base_val = mpbl_pkg::CFG_DATA_W'(BASE_DEF[m]);
						gain_val = mpbl_pkg::CFG_DATA_W'(GAIN_DEF[m]);
					end
					default: begin
						base_val = mpbl_pkg::CFG_DATA_W'($urandom);
						gain_val = mpbl_pkg::CFG_DATA_W'($urandom);
					end
				endcase
				write_reg(mpbl_pkg::CFG_IDX_W'(mpbl_pkg::REG_BASE_LEFT + m), base_val);
				write_reg(mpbl_pkg::CFG_IDX_W'(mpbl_pkg::REG_GAIN_LEFT + m), gain_val);
			end
			// unmapped index must not disturb anything
			write_reg(mpbl_pkg::CFG_IDX_W'(mpbl_pkg::REG_GAIN_HEAD)
				+ mpbl_pkg::CFG_IDX_W'($urandom_range(1, 8)),
				mpbl_pkg::CFG_DATA_W'($urandom));
			cfg_ch.valid <= 1'b0;

			case (phase)
				0: begin src_gap_max = 13; snk_gap_max = 13; end
				1: begin src_gap_max = 0;  snk_gap_max = 0;  end
				2: begin src_gap_max = 0;  snk_gap_max = 13; hold_res = 1'b1; end
				3: begin src_gap_max = 13; snk_gap_max = 0;  end
				4: begin src_gap_max = 3;  snk_gap_max = 3;  end
				default: begin src_gap_max = 13; snk_gap_max = 13; end
			endcase

			sent = 0;
			while (sent < PHASE_ITEMS) begin
				burst_motor = mpbl_pkg::MOTOR_W'($urandom_range(0, 3));
				burst_chg   = 1'($urandom_range(0, 1));
				burst_len   = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 150)
					: $urandom_range(1, 20);
				for (int k = 0; k < burst_len && sent < PHASE_ITEMS; k++) begin
					sel = ($urandom_range(0, 4) == 0)
						? mpbl_pkg::MOTOR_W'($urandom_range(0, 3)) : burst_motor;
					chg = burst_chg ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 7) == 0);
					case ($urandom_range(0, 3))
						0: spd = '0;
						1: spd = mpbl_pkg::SPEED_W'($urandom_range(0, 7));
						2: spd = mpbl_pkg::SPEED_W'($urandom >> $urandom_range(1, 31));
						default: spd = mpbl_pkg::SPEED_W'($urandom);
					endcase
					case ($urandom_range(0, 5))
						0: pw = 16'sh7FFF;
						1: pw = 16'sh8000;
						2: pw = mpbl_pkg::POWER_W'($urandom_range(0, 2000))
							- mpbl_pkg::POWER_W'(1000);
						default: pw = mpbl_pkg::POWER_W'($urandom);
					endcase
					send_req(sel, pw, chg, spd);
					sent++;
				end
			end
		end

		req_ch.valid <= 1'b0;
		wait (pending == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		end_check = 1'b1;
		@(posedge clk);
		@(negedge clk);
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
